FILE: rtl/pcfpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfpt_pkg
// Shared constants and types of the phase current filter and peak tracker.
// ----------------------------------------------------------------------------
package pcfpt_pkg;

  // Filter weight in Q1.16; one is 65536, larger writes are clamped to it.
  localparam int ALPHA_W     = 17;
  localparam int ALPHA_SHIFT = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;

  // Zero-current converter counts after reset.
  localparam int OFFSET_U_RST = 2464;
  localparam int OFFSET_V_RST = 2455;

  // 48 mA per count, built as 32 + 16.
  localparam int MA_SHIFT_HI = 5;
  localparam int MA_SHIFT_LO = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OFFSET_U = 2'd0;
  localparam cfg_idx_t CFG_OFFSET_V = 2'd1;
  localparam cfg_idx_t CFG_ALPHA    = 2'd2;

endpackage

FILE: rtl/phase_current_filter_peak_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_current_filter_peak_tracker_unit
// Offset removal, exponential filtering, mA conversion and peak tracking of
// two measured phase currents and the derived third phase.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_ready does not stall the pipeline;
// the filter register update (subtract, 30x18 multiply, add) is combinational.
// Reset: synchronous, active low; filters and peaks clear to zero, offsets
// return to 2464 and 2455 and the filter weight to 6554, the pipeline empties.
//
// The pipeline has four register stages:
//   A  input register holding the raw converter samples,
//   B  the two filter registers (they are both state and stage payload),
//   C  the three currents converted to mA,
//   D  the output register, with the running maximum and minimum.
// Each stage loads when it is empty or when the stage after it loads in the
// same cycle, so bubbles are squeezed out and a new item is taken while a
// finished result still waits at the output. Because a stage's state
// registers are only written when its item moves on, the filter and peak
// registers advance exactly once per item.
//
// Configuration writes are always taken. A weight above one is stored as
// one. Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module phase_current_filter_peak_tracker_unit #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ADC_BITS-1:0]               in_adc_u,
  input  logic [ADC_BITS-1:0]               in_adc_v,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ADC_BITS+6:0]        out_amps_u,
  output logic signed [ADC_BITS+6:0]        out_amps_v,
  output logic signed [ADC_BITS+7:0]        out_amps_w,
  output logic [ADC_BITS+6:0]               out_peak_high,
  output logic signed [ADC_BITS+7:0]        out_peak_low,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  pcfpt_pkg::cfg_idx_t               cfg_index,
  input  logic [pcfpt_pkg::ALPHA_W-1:0]     cfg_data
);
  import pcfpt_pkg::*;

  localparam int FW = ADC_BITS + FRACTION_BITS + 1;
  localparam int AW = ADC_BITS + 7;

  // Configuration registers.
  logic [ADC_BITS-1:0] offset_u_r;
  logic [ADC_BITS-1:0] offset_v_r;
  logic [ALPHA_W-1:0]  alpha_r;

  // Stage valid flags and per-stage load conditions.
  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_b, rdy_c, rdy_d;

  // Stage A payload.
  logic [ADC_BITS-1:0] adc_u_r;
  logic [ADC_BITS-1:0] adc_v_r;

  // Stage B and C outputs.
  logic signed [FW-1:0] filt_u;
  logic signed [FW-1:0] filt_v;
  logic signed [AW-1:0] amps_u_c;
  logic signed [AW-1:0] amps_v_c;
  logic signed [AW:0]   amps_w_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_u_r <= ADC_BITS'(OFFSET_U_RST);
      offset_v_r <= ADC_BITS'(OFFSET_V_RST);
      alpha_r    <= ALPHA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OFFSET_U: offset_u_r <= cfg_data[ADC_BITS-1:0];
        CFG_OFFSET_V: offset_v_r <= cfg_data[ADC_BITS-1:0];
        CFG_ALPHA:    alpha_r    <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A stage may load when it is empty or its item moves on this cycle.
  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign in_ready = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (in_ready) begin
        va_r <= in_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (rdy_c) begin
        vc_r <= vb_r;
      end
      if (rdy_d) begin
        vd_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      adc_u_r <= in_adc_u;
      adc_v_r <= in_adc_v;
    end
  end

  pcfpt_ema #(
    .ADC_BITS      (ADC_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ema_u (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (va_r && rdy_b),
    .adc    (adc_u_r),
    .offset (offset_u_r),
    .alpha  (alpha_r),
    .filt   (filt_u)
  );

  pcfpt_ema #(
    .ADC_BITS      (ADC_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ema_v (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (va_r && rdy_b),
    .adc    (adc_v_r),
    .offset (offset_v_r),
    .alpha  (alpha_r),
    .filt   (filt_v)
  );

  pcfpt_scale #(
    .ADC_BITS      (ADC_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scale (
    .clk    (clk),
    .ld     (vb_r && rdy_c),
    .fu     (filt_u),
    .fv     (filt_v),
    .amps_u (amps_u_c),
    .amps_v (amps_v_c),
    .amps_w (amps_w_c)
  );

  pcfpt_peak #(
    .ADC_BITS (ADC_BITS)
  ) u_peak (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (vc_r && rdy_d),
    .au        (amps_u_c),
    .av        (amps_v_c),
    .aw        (amps_w_c),
    .amps_u    (out_amps_u),
    .amps_v    (out_amps_v),
    .amps_w    (out_amps_w),
    .peak_high (out_peak_high),
    .peak_low  (out_peak_low)
  );

  assign out_valid = vd_r;

`ifndef ASSERT_OFF
  a_alpha_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    alpha_r <= ALPHA_ONE)
    else $error("stored filter weight exceeds one");

  a_out_from_stage_c : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vd_r) |-> $past(vc_r))
    else $error("result appeared without an item in the conversion stage");

  a_no_skip_stage : assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !rdy_c) |=> vb_r && $stable(filt_u) && $stable(filt_v))
    else $error("filter stage lost or overwrote a stalled item");
`endif

endmodule

FILE: rtl/pcfpt_ema.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfpt_ema
// One channel of the exponential filter; the filter register is updated
// once per item that enters this stage.
// ----------------------------------------------------------------------------
module pcfpt_ema #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ld,
  input  logic [ADC_BITS-1:0]                   adc,
  input  logic [ADC_BITS-1:0]                   offset,
  input  logic [pcfpt_pkg::ALPHA_W-1:0]         alpha,
  output logic signed [ADC_BITS+FRACTION_BITS:0] filt
);
  import pcfpt_pkg::*;

  localparam int FW = ADC_BITS + FRACTION_BITS + 1;
  localparam int DW = FW + 1;
  localparam int PW = DW + ALPHA_W + 1;

  logic signed [FW-1:0]       f_r;
  logic signed [FW-1:0]       f_nxt;
  logic signed [ADC_BITS:0]   raw;
  logic signed [FW-1:0]       target;
  logic signed [DW-1:0]       diff;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       prod_sh;
  logic signed [DW-1:0]       f_sum;

  always_comb begin
    raw     = $signed({1'b0, adc}) - $signed({1'b0, offset});
    target  = {raw, {FRACTION_BITS{1'b0}}};
    diff    = DW'(target) - DW'(f_r);
    prod    = PW'(diff) * $signed(PW'({1'b0, alpha}));
    // Arithmetic shift gives the floor of the scaled step.
    prod_sh = prod >>> ALPHA_SHIFT;
    f_sum   = DW'(f_r) + prod_sh[DW-1:0];
    f_nxt   = f_sum[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= '0;
    end else if (ld) begin
      f_r <= f_nxt;
    end
  end

  assign filt = f_r;

`ifndef ASSERT_OFF
  a_alpha_zero_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (ld && alpha == '0) |=> (f_r == $past(f_r)))
    else $error("filter moved with zero weight");

  a_alpha_one_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    (ld && alpha == ALPHA_ONE) |=> (f_r == $past(target)))
    else $error("filter did not reach target with unit weight");
`endif

endmodule

FILE: rtl/pcfpt_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfpt_scale
// Converts the filtered U and V values and the derived W value to mA and
// registers them.
// ----------------------------------------------------------------------------
module pcfpt_scale #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   ld,
  input  logic signed [ADC_BITS+FRACTION_BITS:0] fu,
  input  logic signed [ADC_BITS+FRACTION_BITS:0] fv,
  output logic signed [ADC_BITS+6:0]             amps_u,
  output logic signed [ADC_BITS+6:0]             amps_v,
  output logic signed [ADC_BITS+7:0]             amps_w
);
  import pcfpt_pkg::*;

  localparam int FW = ADC_BITS + FRACTION_BITS + 1;
  localparam int AW = ADC_BITS + 7;

  logic signed [FW:0]   fw;
  logic signed [FW+5:0] fu_x;
  logic signed [FW+5:0] fv_x;
  logic signed [FW+6:0] fw_x;
  logic signed [FW+5:0] mu;
  logic signed [FW+5:0] mv;
  logic signed [FW+6:0] mw;
  logic signed [FW+5:0] mu_sh;
  logic signed [FW+5:0] mv_sh;
  logic signed [FW+6:0] mw_sh;
  logic signed [AW-1:0] amps_u_r;
  logic signed [AW-1:0] amps_v_r;
  logic signed [AW:0]   amps_w_r;

  always_comb begin
    fw    = -((FW+1)'(fu) + (FW+1)'(fv));
    fu_x  = (FW+6)'(fu);
    fv_x  = (FW+6)'(fv);
    fw_x  = (FW+7)'(fw);
    mu    = (fu_x <<< MA_SHIFT_HI) + (fu_x <<< MA_SHIFT_LO);
    mv    = (fv_x <<< MA_SHIFT_HI) + (fv_x <<< MA_SHIFT_LO);
    mw    = (fw_x <<< MA_SHIFT_HI) + (fw_x <<< MA_SHIFT_LO);
    mu_sh = mu >>> FRACTION_BITS;
    mv_sh = mv >>> FRACTION_BITS;
    mw_sh = mw >>> FRACTION_BITS;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      amps_u_r <= mu_sh[AW-1:0];
      amps_v_r <= mv_sh[AW-1:0];
      amps_w_r <= mw_sh[AW:0];
    end
  end

  assign amps_u = amps_u_r;
  assign amps_v = amps_v_r;
  assign amps_w = amps_w_r;

endmodule

FILE: rtl/pcfpt_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfpt_peak
// Running maximum and minimum over the three phase currents, together with
// the output register of the block.
// ----------------------------------------------------------------------------
module pcfpt_peak #(
  parameter int ADC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ld,
  input  logic signed [ADC_BITS+6:0] au,
  input  logic signed [ADC_BITS+6:0] av,
  input  logic signed [ADC_BITS+7:0] aw,
  output logic signed [ADC_BITS+6:0] amps_u,
  output logic signed [ADC_BITS+6:0] amps_v,
  output logic signed [ADC_BITS+7:0] amps_w,
  output logic [ADC_BITS+6:0]        peak_high,
  output logic signed [ADC_BITS+7:0] peak_low
);

  localparam int AW = ADC_BITS + 7;
  localparam int PW = ADC_BITS + 8;

  logic signed [PW-1:0] au_x;
  logic signed [PW-1:0] av_x;
  logic signed [PW-1:0] hi_a;
  logic signed [PW-1:0] hi_b;
  logic signed [PW-1:0] max_nxt;
  logic signed [PW-1:0] lo_a;
  logic signed [PW-1:0] lo_b;
  logic signed [PW-1:0] min_nxt;
  logic signed [PW-1:0] max_r;
  logic signed [PW-1:0] min_r;
  logic signed [AW-1:0] amps_u_r;
  logic signed [AW-1:0] amps_v_r;
  logic signed [PW-1:0] amps_w_r;

  always_comb begin
    au_x    = PW'(au);
    av_x    = PW'(av);
    hi_a    = (au_x > max_r) ? au_x : max_r;
    hi_b    = (av_x > hi_a) ? av_x : hi_a;
    max_nxt = (aw > hi_b) ? aw : hi_b;
    lo_a    = (au_x < min_r) ? au_x : min_r;
    lo_b    = (av_x < lo_a) ? av_x : lo_a;
    min_nxt = (aw < lo_b) ? aw : lo_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      min_r <= '0;
    end else if (ld) begin
      max_r <= max_nxt;
      min_r <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      amps_u_r <= au;
      amps_v_r <= av;
      amps_w_r <= aw;
    end
  end

  assign amps_u    = amps_u_r;
  assign amps_v    = amps_v_r;
  assign amps_w    = amps_w_r;
  assign peak_high = max_r[AW-1:0];
  assign peak_low  = min_r;

`ifndef ASSERT_OFF
  a_peak_signs : assert property (@(posedge clk) disable iff (!rst_n)
    (max_r >= 0) && (min_r <= 0))
    else $error("peak registers left their half of the range");

  a_peak_covers : assert property (@(posedge clk) disable iff (!rst_n)
    ld |=> (max_r >= $past(au_x)) && (max_r >= $past(av_x)) && (max_r >= $past(aw))
        && (min_r <= $past(au_x)) && (min_r <= $past(av_x)) && (min_r <= $past(aw)))
    else $error("peak registers do not bound the latest item");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the phase current filter and peak tracker. Named
// tests drive converter sample pairs and register writes through the
// valid/ready ports. A bit-exact fixed-point model of the offset removal,
// exponential filter, mA conversion and peak tracking predicts every result,
// and a checker compares each result, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
  import pcfpt_pkg::*;

  localparam int ADC_W       = 12;
  localparam int FRAC_W      = 16;
  localparam int MA_PER_CNT  = 48;
  localparam int ADC_MAX     = (1 << ADC_W) - 1;
  localparam int DATA_MAX    = (1 << ALPHA_W) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 20;

  // The index port is two bits wide; the fourth code selects no register.
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ADC_W+6:0] amps_u;
    logic [ADC_W+6:0] amps_v;
    logic [ADC_W+7:0] amps_w;
    logic [ADC_W+6:0] peak_high;
    logic [ADC_W+7:0] peak_low;
  } currents_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ADC_W-1:0]   in_adc_u = '0;
  logic [ADC_W-1:0]   in_adc_v = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ADC_W+6:0]   out_amps_u;
  logic [ADC_W+6:0]   out_amps_v;
  logic [ADC_W+7:0]   out_amps_w;
  logic [ADC_W+6:0]   out_peak_high;
  logic [ADC_W+7:0]   out_peak_low;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_OFFSET_U;
  logic [ALPHA_W-1:0] cfg_data = '0;

  phase_current_filter_peak_tracker_unit #(
    .ADC_BITS      (ADC_W),
    .FRACTION_BITS (FRAC_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_u      (in_adc_u),
    .in_adc_v      (in_adc_v),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_amps_u    (out_amps_u),
    .out_amps_v    (out_amps_v),
    .out_amps_w    (out_amps_w),
    .out_peak_high (out_peak_high),
    .out_peak_low  (out_peak_low),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Fixed-point model of the block. The filter state is kept in converter
  // counts with FRAC_W fraction bits; longint leaves plenty of headroom for
  // the products, and >>> on a signed value floors, just as the block does.
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0]   model_off_u;
  logic [ADC_W-1:0]   model_off_v;
  logic [ALPHA_W-1:0] model_alpha;
  longint             filt_u;
  longint             filt_v;
  longint             peak_max;
  longint             peak_min;

  currents_t pending_currents[$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        cycle_count = 0;
  bit        idling_on = 1'b0;

  function automatic void reset_model();
    model_off_u = ADC_W'(OFFSET_U_RST);
    model_off_v = ADC_W'(OFFSET_V_RST);
    model_alpha = ALPHA_RST;
    filt_u      = 0;
    filt_v      = 0;
    peak_max    = 0;
    peak_min    = 0;
  endfunction

  // One filter step: move toward the offset-corrected sample by alpha of the
  // remaining distance, floored.
  function automatic longint filter_update(longint f, logic [ADC_W-1:0] adc,
                                           logic [ADC_W-1:0] off, longint alpha);
    longint target;
    target = (longint'(adc) - longint'(off)) <<< FRAC_W;
    return f + (((target - f) * alpha) >>> ALPHA_SHIFT);
  endfunction

  function automatic longint counts_to_ma(longint f);
    return (f * MA_PER_CNT) >>> FRAC_W;
  endfunction

  function automatic void track_peak(longint ma);
    if (ma > peak_max) peak_max = ma;
    if (ma < peak_min) peak_min = ma;
  endfunction

  function automatic currents_t predict_currents(logic [ADC_W-1:0] adc_u,
                                                 logic [ADC_W-1:0] adc_v);
    currents_t res;
    longint    alpha;
    longint    ma_u;
    longint    ma_v;
    longint    ma_w;
    // Weights above one behave as exactly one.
    alpha  = (model_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(model_alpha);
    filt_u = filter_update(filt_u, adc_u, model_off_u, alpha);
    filt_v = filter_update(filt_v, adc_v, model_off_v, alpha);
    ma_u   = counts_to_ma(filt_u);
    ma_v   = counts_to_ma(filt_v);
    ma_w   = counts_to_ma(-(filt_u + filt_v));
    // Peaks follow the freshly filtered values of this very item.
    track_peak(ma_u);
    track_peak(ma_v);
    track_peak(ma_w);
    res.amps_u    = ma_u[ADC_W+6:0];
    res.amps_v    = ma_v[ADC_W+6:0];
    res.amps_w    = ma_w[ADC_W+7:0];
    res.peak_high = peak_max[ADC_W+6:0];
    res.peak_low  = peak_min[ADC_W+7:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [ADC_W+7:0] got,
                                 input logic [ADC_W+7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("MISMATCH %s at result %0d: got %h, wanted %h", what, result_count,
               got, want);
    end
  endtask

  currents_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_currents.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_currents.pop_front();
        if (out_amps_u !== want.amps_u)
          report_mismatch("amps_u", (ADC_W+8)'(out_amps_u), (ADC_W+8)'(want.amps_u));
        if (out_amps_v !== want.amps_v)
          report_mismatch("amps_v", (ADC_W+8)'(out_amps_v), (ADC_W+8)'(want.amps_v));
        if (out_amps_w !== want.amps_w)
          report_mismatch("amps_w", out_amps_w, want.amps_w);
        if (out_peak_high !== want.peak_high)
          report_mismatch("peak_high", (ADC_W+8)'(out_peak_high),
                          (ADC_W+8)'(want.peak_high));
        if (out_peak_low !== want.peak_low)
          report_mismatch("peak_low", out_peak_low, want.peak_low);
      end
      result_count++;
    end
  end

  // The receiver stalls in random bursts while idling is enabled.
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks. Every task starts and ends right after a falling
  // edge, and an item keeps in_valid high into the next call so that back to
  // back items never drop valid.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [ADC_W-1:0] adc_u,
                             input logic [ADC_W-1:0] adc_v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_adc_u <= adc_u;
    in_adc_v <= adc_v;
    do @(posedge clk); while (!in_ready);
    pending_currents.push_back(predict_currents(adc_u, adc_v));
    @(negedge clk);
  endtask

  // Stops the sender and waits until every predicted result has come back,
  // then waits on further so that the pipeline is certainly empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_currents.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Only called with the pipeline drained. Valid drops for one cycle after
  // each write, so consecutive writes never touch cfg_valid twice at once.
  task automatic write_register(input cfg_idx_t idx, input logic [ALPHA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OFFSET_U: model_off_u = data[ADC_W-1:0];
      CFG_OFFSET_V: model_off_v = data[ADC_W-1:0];
      CFG_ALPHA:    model_alpha = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_filter(input int off_u, input int off_v, input int alpha);
    drain_pipeline();
    write_register(CFG_OFFSET_U, ALPHA_W'(off_u));
    write_register(CFG_OFFSET_V, ALPHA_W'(off_v));
    write_register(CFG_ALPHA, ALPHA_W'(alpha));
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset offsets and weight: converter extremes and a pair right at zero.
  task automatic test_reset_values();
    send_sample('0, '0);
    send_sample(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
    send_sample(ADC_W'(OFFSET_U_RST), ADC_W'(OFFSET_V_RST));
    send_sample(ADC_W'(ADC_MAX), '0);
    send_sample('0, ADC_W'(ADC_MAX));
  endtask

  // With a weight of one the filter lands on the target at once, so each
  // offset setting below drives one phase to its full-scale current and
  // pushes the peaks to both ends of their range.
  task automatic test_full_scale();
    setup_filter(0, ADC_MAX, ALPHA_ONE);
    send_sample(ADC_W'(ADC_MAX), '0);
    send_sample(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
    setup_filter(ADC_MAX, 0, ALPHA_ONE);
    send_sample('0, ADC_W'(ADC_MAX));
    send_sample('0, '0);
    setup_filter(ADC_MAX, ADC_MAX, ALPHA_ONE);
    send_sample('0, '0);
    send_sample(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
    setup_filter(0, 0, ALPHA_ONE);
    send_sample(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX));
    send_sample('0, '0);
  endtask

  // Weights above one must behave exactly like one.
  task automatic test_alpha_above_one();
    setup_filter(2048, 1024, DATA_MAX);
    send_sample(12'h5A5, 12'hA5A);
    drain_pipeline();
    write_register(CFG_ALPHA, ALPHA_W'(ALPHA_ONE + 1));
    send_sample(12'hFFF, 12'h001);
  endtask

  // A weight of zero freezes both filters whatever the samples do.
  task automatic test_alpha_zero();
    setup_filter(100, 3900, 0);
    send_sample('0, ADC_W'(ADC_MAX));
    send_sample(ADC_W'(ADC_MAX), '0);
    send_sample(12'h800, 12'h7FF);
  endtask

  // Writes to the unassigned index must change nothing.
  task automatic test_unused_index();
    drain_pipeline();
    write_register(CFG_ALPHA, ALPHA_W'(30000));
    write_register(CFG_UNUSED, ALPHA_W'(DATA_MAX));
    send_sample(12'hC00, 12'h300);
    drain_pipeline();
    write_register(CFG_UNUSED, '0);
    send_sample(12'h123, 12'hEDC);
  endtask

  function automatic logic [ADC_W-1:0] near_offset(logic [ADC_W-1:0] off);
    int s;
    s = int'(off) + $urandom_range(0, 64) - 32;
    if (s < 0) s = 0;
    if (s > ADC_MAX) s = ADC_MAX;
    return ADC_W'(s);
  endfunction

  function automatic logic [ALPHA_W-1:0] random_offset_data();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALPHA_W'(ADC_MAX);
      // Upper data bits are set too; the offset keeps only the low bits.
      default: return ALPHA_W'($urandom_range(0, DATA_MAX));
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] random_alpha();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALPHA_ONE;
      2:       return ALPHA_W'($urandom_range(ALPHA_ONE + 1, DATA_MAX));
      3:       return ALPHA_W'($urandom_range(1, 256));
      4:       return ALPHA_W'($urandom_range(60000, ALPHA_ONE - 1));
      default: return ALPHA_W'($urandom_range(0, ALPHA_ONE));
    endcase
  endfunction

  task automatic send_random_samples(input int count);
    logic [ADC_W-1:0] u;
    logic [ADC_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          u = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
          v = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
        end
        1: begin
          u = near_offset(model_off_u);
          v = near_offset(model_off_v);
        end
        default: begin
          u = ADC_W'($urandom_range(0, ADC_MAX));
          v = ADC_W'($urandom_range(0, ADC_MAX));
        end
      endcase
      send_sample(u, v);
      // Now and then the sender holds off until everything has come back.
      if ($urandom_range(0, 299) == 0) drain_pipeline();
    end
  endtask

  // Random phases, each possibly with fresh register settings; idling is
  // switched on for most phases and off for the final stretch.
  task automatic test_random_phases();
    for (int phase = 0; phase < 12; phase++) begin
      drain_pipeline();
      if ($urandom_range(0, 2) != 0) write_register(CFG_OFFSET_U, random_offset_data());
      if ($urandom_range(0, 2) != 0) write_register(CFG_OFFSET_V, random_offset_data());
      if ($urandom_range(0, 2) != 0) write_register(CFG_ALPHA, random_alpha());
      if ($urandom_range(0, 5) == 0)
        write_register(CFG_UNUSED, ALPHA_W'($urandom_range(0, DATA_MAX)));
      idling_on = ($urandom_range(0, 3) != 0);
      send_random_samples($urandom_range(90, 150));
      if (phase == 5) begin
        // Explicit pause: the sender waits for every outstanding result.
        drain_pipeline();
        send_random_samples(20);
      end
    end
    drain_pipeline();
    write_register(CFG_ALPHA, random_alpha());
    idling_on = 1'b0;
    send_random_samples(200);
  endtask

  initial begin
    reset_model();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idling_on = 1'b1;

    test_reset_values();
    test_full_scale();
    test_alpha_above_one();
    test_alpha_zero();
    test_unused_index();
    test_random_phases();

    drain_pipeline();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
